FILE: design/nearest_plane_reduction_macros.svh
`ifndef NEAREST_PLANE_REDUCTION_MACROS_SVH
`define NEAREST_PLANE_REDUCTION_MACROS_SVH

// same-cycle implication, disabled during reset
`define NPR_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error("nearest_plane_reduction assertion failed");

// next-cycle implication, disabled during reset
`define NPR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error("nearest_plane_reduction assertion failed");

`endif

FILE: design/npr_pkg.sv
`default_nettype none
package npr_pkg;

    localparam int MAX_DIM    = 64;
    localparam int IDX_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = IDX_W + 1;
    localparam int VALUE_BITS = 48;
    localparam int CNT_W      = $clog2(VALUE_BITS);
    localparam int CFG_W      = 7;

    typedef enum logic [1:0] {
        CMD_LOAD_BASIS  = 2'd0,
        CMD_LOAD_TARGET = 2'd1,
        CMD_RUN         = 2'd2,
        CMD_NONE        = 2'd3
    } t_cmd;

    typedef enum logic {
        CFG_DIMENSION    = 1'b0,
        CFG_REDUCE_COUNT = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_D_RD,
        S_DIV_INIT,
        S_DIV,
        S_DIV_FIN,
        S_NEXT_I,
        S_J_RD,
        S_MUL_INIT,
        S_MUL,
        S_SUB,
        S_EM_RD,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd                          command;
        logic [IDX_W-1:0]              row;
        logic [IDX_W-1:0]              col;
        logic signed [VALUE_BITS-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]              index;
        logic signed [VALUE_BITS-1:0]  reduced_value;
        logic                          divide_fault;
        logic                          last;
    } t_out_item;

    function automatic logic [VALUE_BITS-1:0] magnitude(input logic [VALUE_BITS-1:0] x);
        magnitude = x[VALUE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

endpackage
`default_nettype wire

FILE: design/nearest_plane_reduction.sv
// loads are taken only while idle and return nothing; a run reduces r columns
//   and returns one result for each reduced column
// one shared restoring divider and one shift-add multiplier, one bit per cycle each
// busy is high for the whole run; results stream out at the end, via S_EM_RD then S_EMIT
// the receiver cannot stall; synchronous active-low reset clears control state only
`default_nettype none
`include "nearest_plane_reduction_macros.svh"
module nearest_plane_reduction
    import npr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_in_item          i_item,
    output logic                   o_valid,
    output t_out_item              o_result,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    localparam int VB = VALUE_BITS;
    localparam int PW = VB + 2;

    logic [VB-1:0] basis_mem [MAX_DIM*MAX_DIM];
    logic [VB-1:0] target_mem [MAX_DIM];

    t_state r_state, n_state;
    logic [CFG_W-1:0] r_dim, r_rcount;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_lo, n_lo, r_k, n_k;
    logic [DIM_W-1:0] r_r, n_r;
    logic r_fault, n_fault;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [VB-1:0] r_dm, n_dm, r_q, n_q, r_rem, n_rem, r_cm, n_cm, r_bm, n_bm;
    logic r_neg, n_neg, r_pneg, n_pneg, r_sat, n_sat;
    logic [PW-1:0] r_acc, n_acc;
    logic signed [VB-1:0] r_t, n_t;
    logic [VB-1:0] r_bdata, r_tdata;

    logic [2*IDX_W-1:0] b_raddr, b_waddr;
    logic [IDX_W-1:0] t_raddr, t_waddr;
    logic b_we, t_we;
    logic [VB-1:0] b_wdata, t_wdata;

    logic [DIM_W-1:0] m_c, red_c;
    logic [VB:0] rem_sh;
    logic [PW-1:0] lim, acc_nx, p_mag;
    logic signed [PW-1:0] prod, diff;
    logic [VB-1:0] q_rnd;

    logic accept;
    assign accept = start && !busy;
    // no write is taken while reset is held
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim    <= CFG_W'(MAX_DIM);
            r_rcount <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_DIMENSION:    r_dim    <= i_cfg_data;
                CFG_REDUCE_COUNT: r_rcount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_we) begin
            basis_mem[b_waddr] <= b_wdata;
        end
        r_bdata <= basis_mem[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            target_mem[t_waddr] <= t_wdata;
        end
        r_tdata <= target_mem[t_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fault <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fault <= n_fault;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_lo   <= n_lo;
        r_k    <= n_k;
        r_r    <= n_r;
        r_cnt  <= n_cnt;
        r_dm   <= n_dm;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_cm   <= n_cm;
        r_bm   <= n_bm;
        r_neg  <= n_neg;
        r_pneg <= n_pneg;
        r_sat  <= n_sat;
        r_acc  <= n_acc;
        r_t    <= n_t;
    end

    // clamp dimension and reduce count
    always_comb begin
        if (r_dim == '0) begin
            m_c = DIM_W'(1);
        end else if (r_dim > CFG_W'(MAX_DIM)) begin
            m_c = DIM_W'(MAX_DIM);
        end else begin
            m_c = DIM_W'(r_dim);
        end
        if (r_rcount == '0 || r_rcount > CFG_W'(m_c)) begin
            red_c = m_c;
        end else begin
            red_c = DIM_W'(r_rcount);
        end
    end

    // shared datapath pieces
    assign rem_sh = {r_rem, r_q[VB-1]};
    assign q_rnd  = r_q + VB'(r_rem >= (r_dm - r_rem));
    assign lim    = (PW'(1) << (VB-1)) - PW'(!r_pneg);
    assign acc_nx = {r_acc[PW-2:0], 1'b0}
                  + (r_cm[CNT_W'(VB-1) - r_cnt] ? PW'(r_bm) : PW'(0));
    assign p_mag  = r_sat ? lim : r_acc;
    assign prod   = r_pneg ? -$signed(p_mag) : $signed(p_mag);
    assign diff   = PW'(r_t) - prod;

    always_comb begin
        n_state = r_state;
        n_i = r_i; n_j = r_j; n_lo = r_lo; n_k = r_k; n_r = r_r;
        n_fault = r_fault; n_cnt = r_cnt;
        n_dm = r_dm; n_q = r_q; n_rem = r_rem; n_cm = r_cm; n_bm = r_bm;
        n_neg = r_neg; n_pneg = r_pneg; n_sat = r_sat; n_acc = r_acc; n_t = r_t;
        b_we = 1'b0; t_we = 1'b0;
        b_waddr = {i_item.row, i_item.col};
        b_wdata = i_item.value;
        t_waddr = i_item.row;
        t_wdata = i_item.value;
        b_raddr = {r_i, r_i};
        t_raddr = r_i;
        busy = (r_state != S_IDLE) || !i_rst_n;
        o_valid = 1'b0;
        o_result.index = r_k;
        o_result.reduced_value = r_tdata;
        o_result.divide_fault = r_fault;
        o_result.last = ({1'b0, r_k} == r_r - DIM_W'(1));

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_item.command)
                        CMD_LOAD_BASIS:  b_we = 1'b1;
                        CMD_LOAD_TARGET: t_we = 1'b1;
                        CMD_RUN: begin
                            n_r     = red_c;
                            n_lo    = IDX_W'(m_c - red_c);
                            n_i     = IDX_W'(m_c - DIM_W'(1));
                            n_fault = 1'b0;
                            n_state = S_D_RD;
                        end
                        CMD_NONE: ;
                        default: ;
                    endcase
                end
            end
            S_D_RD: begin
                n_state = S_DIV_INIT;
            end
            S_DIV_INIT: begin
                if (r_bdata == '0) begin
                    n_fault = 1'b1;
                    n_state = S_NEXT_I;
                end else begin
                    n_dm    = magnitude(r_bdata);
                    n_q     = magnitude(r_tdata);
                    n_rem   = '0;
                    n_neg   = r_bdata[VB-1] ^ r_tdata[VB-1];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                // restoring division, one quotient bit per cycle
                if (rem_sh >= {1'b0, r_dm}) begin
                    n_rem = VB'(rem_sh - {1'b0, r_dm});
                    n_q   = {r_q[VB-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[VB-1:0];
                    n_q   = {r_q[VB-2:0], 1'b0};
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VB-1)) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                // round half away from zero on magnitudes
                n_cm = q_rnd;
                if (q_rnd == '0) begin
                    n_state = S_NEXT_I;
                end else begin
                    n_j     = r_i;
                    n_state = S_J_RD;
                end
            end
            S_NEXT_I: begin
                if (r_i == r_lo) begin
                    n_k     = '0;
                    n_state = S_EM_RD;
                end else begin
                    n_i     = r_i - IDX_W'(1);
                    n_state = S_D_RD;
                end
            end
            S_J_RD: begin
                b_raddr = {r_j, r_i};
                t_raddr = r_j;
                n_state = S_MUL_INIT;
            end
            S_MUL_INIT: begin
                n_bm    = magnitude(r_bdata);
                n_pneg  = r_neg ^ r_bdata[VB-1];
                n_t     = r_tdata;
                n_acc   = '0;
                n_sat   = 1'b0;
                n_cnt   = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                // msb-first shift-add; acc only grows, so saturation is sticky
                if (!r_sat) begin
                    if (acc_nx > lim) begin
                        n_sat = 1'b1;
                    end else begin
                        n_acc = acc_nx;
                    end
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(VB-1)) begin
                    n_state = S_SUB;
                end
            end
            S_SUB: begin
                t_we    = 1'b1;
                t_waddr = r_j;
                if (diff > $signed(PW'((PW'(1) << (VB-1)) - PW'(1)))) begin
                    t_wdata = {1'b0, {(VB-1){1'b1}}};
                end else if (diff < -$signed(PW'(1) << (VB-1))) begin
                    t_wdata = {1'b1, {(VB-1){1'b0}}};
                end else begin
                    t_wdata = diff[VB-1:0];
                end
                if (r_j == r_lo) begin
                    n_state = S_NEXT_I;
                end else begin
                    n_j     = r_j - IDX_W'(1);
                    n_state = S_J_RD;
                end
            end
            S_EM_RD: begin
                t_raddr = r_lo + r_k;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                o_valid = 1'b1;
                if (o_result.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + IDX_W'(1);
                    n_state = S_EM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `NPR_ASSERT_NOW(a_valid_in_run, o_valid, busy && r_state == S_EMIT)
    `NPR_ASSERT_NEXT(a_last_ends_run, o_valid && o_result.last, !busy && !o_valid)
    `NPR_ASSERT_NEXT(a_run_goes_busy, accept && i_item.command == CMD_RUN, busy)
    `NPR_ASSERT_NOW(a_mul_nonzero, r_state == S_MUL, r_cm != '0)

endmodule
`default_nettype wire
